FILE: sv/efr_pkg.sv
package efr_pkg;

	localparam int unsigned CHANNELS_DEF      = 2;
	localparam int unsigned PAYLOAD_DEPTH_DEF = 256;

	localparam logic [7:0] MARK_BYTE = 8'hEE;
	localparam logic [7:0] ESC_BYTE  = 8'hFF;
	localparam logic [7:0] MIN_WIRE  = 8'd4;

	typedef enum logic {
		CMD_RX   = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		PH_HEAD = 3'd0,
		PH_LEN  = 3'd1,
		PH_PROP = 3'd2,
		PH_DATA = 3'd3,
		PH_TAIL = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] wire_remaining;
		logic [7:0] payload_count;
		logic [7:0] prop_byte;
		logic [7:0] previous_byte;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		phase:          PH_HEAD,
		wire_remaining: 8'd0,
		payload_count:  8'd0,
		prop_byte:      8'd0,
		previous_byte:  8'd0
	};

endpackage

FILE: sv/escaped_frame_receiver_unit.sv
// Pipeline: an accepted transfer passes through the stage 1 registers and then the output register.
// Throughput: one item per cycle while the output register is free or drained; context and payload
// memories are read at acceptance and written back as the item leaves stage 1, with forwarding on a repeat.
// Reset (arst_n low, asynchronous): every channel context reads as "waiting
// for head mark" with zero counters; payload bytes stay undefined until written.
module escaped_frame_receiver_unit #(
	parameter int unsigned CHANNELS      = efr_pkg::CHANNELS_DEF,
	parameter int unsigned PAYLOAD_DEPTH = efr_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic       channel,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       frame_done,
	output logic [7:0] frame_prop,
	output logic [7:0] frame_length,
	output logic [7:0] read_data
);

	// Channel index and payload position widths
	localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned PW        = $clog2(PAYLOAD_DEPTH);
	localparam int unsigned AW        = CH_W + PW;
	localparam int unsigned PAY_SLOTS = CHANNELS << PW;
	localparam logic [8:0]  DEPTH_LIM = 9'(PAYLOAD_DEPTH);

	// ------------------------------------------------------------------
	// Acceptance stage: decode the transfer and launch memory reads
	// ------------------------------------------------------------------
	logic            adv;
	logic [CH_W-1:0] ch_idx_in;
	logic            ch_ok_in;
	logic            idx_ok_in;
	logic [AW-1:0]   rd_addr_in;
	logic            take;

	// The whole pipe moves whenever the output register is free or drained.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign take     = in_valid && adv;

	assign ch_idx_in  = CH_W'(channel);
	assign ch_ok_in   = int'(channel) < CHANNELS;
	assign idx_ok_in  = {1'b0, read_index} < DEPTH_LIM;
	assign rd_addr_in = {ch_idx_in, read_index[PW-1:0]};

	// Stage 1 registers: the item waiting for its memory data
	logic             vld_s1;
	efr_pkg::cmd_t    cmd_s1;
	logic [CH_W-1:0]  ch_idx_s1;
	logic             ch_ok_s1;
	logic             idx_ok_s1;
	logic [7:0]       byte_s1;
	logic [AW-1:0]    rd_addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1     <= efr_pkg::cmd_t'(command);
			ch_idx_s1  <= ch_idx_in;
			ch_ok_s1   <= ch_ok_in;
			idx_ok_s1  <= idx_ok_in;
			byte_s1    <= rx_byte;
			rd_addr_s1 <= rd_addr_in;
		end
	end

	// ------------------------------------------------------------------
	// Channel context memory: one entry per channel, registered read
	// ------------------------------------------------------------------
	efr_pkg::ctx_t ctx_mem [CHANNELS];
	efr_pkg::ctx_t ctx_rd_s1;
	efr_pkg::ctx_t ctx_nxt;
	logic          ctx_re;
	logic          ctx_we;

	assign ctx_re = take && ch_ok_in && (efr_pkg::cmd_t'(command) == efr_pkg::CMD_RX);
	assign ctx_we = adv && vld_s1 && ch_ok_s1 && (cmd_s1 == efr_pkg::CMD_RX);

	always_ff @(posedge clk) begin
		if (ctx_re) begin
			ctx_rd_s1 <= ctx_mem[ch_idx_in];
		end
	end

	always_ff @(posedge clk) begin
		if (ctx_we) begin
			ctx_mem[ch_idx_s1] <= ctx_nxt;
		end
	end

	// Written-once flags: an entry never written reads as the reset context.
	logic [CHANNELS-1:0] ctx_init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_init_q <= '0;
		end else if (ctx_we) begin
			ctx_init_q[ch_idx_s1] <= 1'b1;
		end
	end

	// Forward the context written at the previous advancing edge: the
	// item behind it read the memory at that same edge and saw stale data.
	logic            ctx_fwd_valid_q;
	logic [CH_W-1:0] ctx_fwd_ch_q;
	efr_pkg::ctx_t   ctx_fwd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_fwd_valid_q <= 1'b0;
		end else if (adv) begin
			ctx_fwd_valid_q <= ctx_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ctx_we) begin
			ctx_fwd_ch_q <= ch_idx_s1;
			ctx_fwd_q    <= ctx_nxt;
		end
	end

	efr_pkg::ctx_t ctx_cur;

	always_comb begin
		ctx_cur = efr_pkg::CTX_RESET;
		if (ctx_fwd_valid_q && (ctx_fwd_ch_q == ch_idx_s1)) begin
			ctx_cur = ctx_fwd_q;
		end else if (ctx_init_q[ch_idx_s1]) begin
			ctx_cur = ctx_rd_s1;
		end
	end

	// ------------------------------------------------------------------
	// Payload store: PAYLOAD_DEPTH bytes per channel, registered read
	// ------------------------------------------------------------------
	logic [7:0]    pay_mem [PAY_SLOTS];
	logic [7:0]    pay_rd_s1;
	logic          pay_re;
	logic          pay_we;
	logic          pay_we_c;
	logic [PW-1:0] pay_wpos;
	logic [AW-1:0] pay_waddr;

	assign pay_re    = take && ch_ok_in && idx_ok_in &&
		(efr_pkg::cmd_t'(command) == efr_pkg::CMD_READ);
	assign pay_we    = ctx_we && pay_we_c;
	assign pay_waddr = {ch_idx_s1, pay_wpos};

	always_ff @(posedge clk) begin
		if (pay_re) begin
			pay_rd_s1 <= pay_mem[rd_addr_in];
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[pay_waddr] <= byte_s1;
		end
	end

	// Same forwarding idea for a read that follows a store of its byte.
	logic          pay_fwd_valid_q;
	logic [AW-1:0] pay_fwd_addr_q;
	logic [7:0]    pay_fwd_data_q;
	logic [7:0]    pay_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_fwd_valid_q <= 1'b0;
		end else if (adv) begin
			pay_fwd_valid_q <= pay_we;
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_fwd_addr_q <= pay_waddr;
			pay_fwd_data_q <= byte_s1;
		end
	end

	assign pay_cur = (pay_fwd_valid_q && (pay_fwd_addr_q == rd_addr_s1)) ?
		pay_fwd_data_q : pay_rd_s1;

	// ------------------------------------------------------------------
	// Receive state machine, evaluated on the fetched context
	// ------------------------------------------------------------------
	efr_pkg::phase_t ph_eff;
	logic [7:0]      cnt_eff;
	logic [7:0]      wr_dec;

	// Fold unused codes to head, then apply the mark rule outside the tail: an unescaped
	// mark restarts the frame, an escaped one drops the stored escape byte.
	always_comb begin
		case (ctx_cur.phase)
			efr_pkg::PH_HEAD, efr_pkg::PH_LEN, efr_pkg::PH_PROP,
			efr_pkg::PH_DATA, efr_pkg::PH_TAIL: ph_eff = ctx_cur.phase;
			default: ph_eff = efr_pkg::PH_HEAD;
		endcase
		cnt_eff = ctx_cur.payload_count;
		if ((byte_s1 == efr_pkg::MARK_BYTE) && (ph_eff != efr_pkg::PH_TAIL)) begin
			if (ctx_cur.previous_byte != efr_pkg::ESC_BYTE) begin
				ph_eff = efr_pkg::PH_HEAD;
			end else if (cnt_eff != 8'd0) begin
				cnt_eff = cnt_eff - 8'd1;
			end
		end
	end

	assign wr_dec = ctx_cur.wire_remaining - 8'd1;

	// Next state
	always_comb begin
		ctx_nxt               = ctx_cur;
		ctx_nxt.payload_count = cnt_eff;
		ctx_nxt.previous_byte = byte_s1;
		pay_we_c              = 1'b0;
		pay_wpos              = cnt_eff[PW-1:0];
		unique case (ph_eff)
			efr_pkg::PH_HEAD: begin
				ctx_nxt.phase = (byte_s1 == efr_pkg::MARK_BYTE) ?
					efr_pkg::PH_LEN : efr_pkg::PH_HEAD;
			end
			efr_pkg::PH_LEN: begin
				if (byte_s1 < efr_pkg::MIN_WIRE) begin
					ctx_nxt.phase = efr_pkg::PH_HEAD;
				end else begin
					ctx_nxt.wire_remaining = byte_s1;
					ctx_nxt.payload_count  = 8'd0;
					ctx_nxt.phase          = efr_pkg::PH_PROP;
				end
			end
			efr_pkg::PH_PROP: begin
				ctx_nxt.prop_byte = byte_s1;
				ctx_nxt.phase = (ctx_cur.wire_remaining == efr_pkg::MIN_WIRE) ?
					efr_pkg::PH_TAIL : efr_pkg::PH_DATA;
			end
			efr_pkg::PH_DATA: begin
				// Store while in range; count the byte either way.
				ctx_nxt.wire_remaining = wr_dec;
				pay_we_c               = {1'b0, cnt_eff} < DEPTH_LIM;
				ctx_nxt.payload_count  = cnt_eff + 8'd1;
				ctx_nxt.phase = (wr_dec == efr_pkg::MIN_WIRE) ?
					efr_pkg::PH_TAIL : efr_pkg::PH_DATA;
			end
			efr_pkg::PH_TAIL: begin
				ctx_nxt.phase = efr_pkg::PH_HEAD;
			end
			default: begin
				ctx_nxt.phase = efr_pkg::PH_HEAD;
			end
		endcase
	end

	// Result of the item in stage 1
	logic       res_done;
	logic [7:0] res_prop;
	logic [7:0] res_len;
	logic [7:0] res_data;

	always_comb begin
		res_done = 1'b0;
		res_prop = 8'd0;
		res_len  = 8'd0;
		res_data = 8'd0;
		if (ch_ok_s1) begin
			if (cmd_s1 == efr_pkg::CMD_READ) begin
				if (idx_ok_s1) begin
					res_data = pay_cur;
				end
			end else if ((ph_eff == efr_pkg::PH_TAIL) &&
				(byte_s1 == efr_pkg::MARK_BYTE)) begin
				res_done = 1'b1;
				res_prop = ctx_cur.prop_byte;
				res_len  = cnt_eff;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register: holds a result until its transfer completes
	// ------------------------------------------------------------------
	logic       out_valid_q;
	logic       frame_done_q;
	logic [7:0] frame_prop_q;
	logic [7:0] frame_length_q;
	logic [7:0] read_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			frame_done_q   <= res_done;
			frame_prop_q   <= res_prop;
			frame_length_q <= res_len;
			read_data_q    <= res_data;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_done   = frame_done_q;
	assign frame_prop   = frame_prop_q;
	assign frame_length = frame_length_q;
	assign read_data    = read_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s1))
		else $error("result appeared with no item in stage 1");

	a_done_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_done_q) |-> (read_data_q == 8'd0))
		else $error("frame report carries read data");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_done_q) |-> (frame_length_q <= 8'd251))
		else $error("frame length beyond wire length limit");

	a_write_only_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_we || pay_we) |-> (adv && vld_s1))
		else $error("memory write while the pipe is stalled");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Checks escaped_frame_receiver_unit against a cycle-free model of the per-channel
// frame decoder and payload store. Every accepted transfer yields one reply, so
// replies are matched in order against a queue of predicted replies.
module tb_top;

	// Run-length guard: far above the slowest legal run of ~1550 transfers.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Detailed mismatch reports before going quiet.
	localparam int unsigned REPORT_MAX  = 10;

	typedef struct packed {
		logic       frame_done;
		logic [7:0] frame_prop;
		logic [7:0] frame_length;
		logic [7:0] read_data;
	} frame_reply_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_ready;
	logic       command      = 1'b0;
	logic       channel      = 1'b0;
	logic [7:0] rx_byte      = 8'd0;
	logic [7:0] read_index   = 8'd0;
	logic       out_valid;
	logic       out_ready    = 1'b0;
	logic       frame_done;
	logic [7:0] frame_prop;
	logic [7:0] frame_length;
	logic [7:0] read_data;

	// Model state: one decoder context and one payload store per channel.
	efr_pkg::ctx_t chan_ctx      [efr_pkg::CHANNELS_DEF];
	logic [7:0]    payload_mem   [efr_pkg::CHANNELS_DEF][efr_pkg::PAYLOAD_DEPTH_DEF];
	logic          payload_valid [efr_pkg::CHANNELS_DEF][efr_pkg::PAYLOAD_DEPTH_DEF];

	// Replies predicted at input acceptance, oldest first.
	frame_reply_t expected_replies[$];

	// Wire bytes still to be sent per channel; random traffic interleaves them.
	logic [7:0] wire_q0[$];
	logic [7:0] wire_q1[$];

	int unsigned sender_idle_pct = 0;
	int unsigned sink_stall_pct  = 0;
	int unsigned hold_epoch      = 0;
	int unsigned hold_len        = 0;
	int unsigned fail_count      = 0;
	int unsigned cycle_count     = 0;

	escaped_frame_receiver_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.channel      (channel),
		.rx_byte      (rx_byte),
		.read_index   (read_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_done   (frame_done),
		.frame_prop   (frame_prop),
		.frame_length (frame_length),
		.read_data    (read_data)
	);

	always #1 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Decode one accepted transfer the way the block must, and advance the model.
	function automatic frame_reply_t rx_decode(input efr_pkg::cmd_t cmd, input logic ch,
			input logic [7:0] b, input logic [7:0] ri);
		frame_reply_t    r;
		efr_pkg::ctx_t   c;
		efr_pkg::phase_t ph;
		r = '0;
		if (cmd == efr_pkg::CMD_READ) begin
			r.read_data = payload_mem[ch][ri];
			return r;
		end
		c  = chan_ctx[ch];
		ph = c.phase;
		// An unescaped mark outside the tail restarts the frame; an escaped one
		// takes back the escape byte that was already counted.
		if (b == efr_pkg::MARK_BYTE && ph != efr_pkg::PH_TAIL) begin
			if (c.previous_byte != efr_pkg::ESC_BYTE) begin
				ph = efr_pkg::PH_HEAD;
			end else if (c.payload_count != 8'd0) begin
				c.payload_count = c.payload_count - 8'd1;
			end
		end
		case (ph)
			efr_pkg::PH_HEAD: begin
				if (b == efr_pkg::MARK_BYTE)
					ph = efr_pkg::PH_LEN;
			end
			efr_pkg::PH_LEN: begin
				if (b < efr_pkg::MIN_WIRE) begin
					ph = efr_pkg::PH_HEAD;
				end else begin
					c.wire_remaining = b;
					c.payload_count  = 8'd0;
					ph               = efr_pkg::PH_PROP;
				end
			end
			efr_pkg::PH_PROP: begin
				c.prop_byte = b;
				ph = (c.wire_remaining == efr_pkg::MIN_WIRE) ?
					efr_pkg::PH_TAIL : efr_pkg::PH_DATA;
			end
			efr_pkg::PH_DATA: begin
				c.wire_remaining = c.wire_remaining - 8'd1;
				payload_mem[ch][c.payload_count]   = b;
				payload_valid[ch][c.payload_count] = 1'b1;
				c.payload_count = c.payload_count + 8'd1;
				if (c.wire_remaining == efr_pkg::MIN_WIRE)
					ph = efr_pkg::PH_TAIL;
			end
			default: begin
				if (b == efr_pkg::MARK_BYTE) begin
					r.frame_done   = 1'b1;
					r.frame_prop   = c.prop_byte;
					r.frame_length = c.payload_count;
				end
				ph = efr_pkg::PH_HEAD;
			end
		endcase
		c.phase         = ph;
		c.previous_byte = b;
		chan_ctx[ch]    = c;
		return r;
	endfunction

	// Offer one transfer at the falling edge, hold it until accepted, then
	// predict its reply.
	task automatic send_item(input efr_pkg::cmd_t cmd, input logic ch,
			input logic [7:0] b, input logic [7:0] ri);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		command    = cmd;
		channel    = ch;
		rx_byte    = b;
		read_index = ri;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_replies.push_back(rx_decode(cmd, ch, b, ri));
	endtask

	task automatic send_rx(input logic ch, input logic [7:0] b);
		send_item(efr_pkg::CMD_RX, ch, b, 8'($urandom_range(255)));
	endtask

	task automatic send_read(input logic ch, input logic [7:0] ri);
		send_item(efr_pkg::CMD_READ, ch, 8'($urandom_range(255)), ri);
	endtask

	// Drop valid and wait until every predicted reply has been seen.
	task automatic wait_replies_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_data_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		while (b == efr_pkg::MARK_BYTE)
			b = 8'($urandom_range(255));
		return b;
	endfunction

	function automatic void push_wire(input logic ch, input logic [7:0] b);
		if (ch)
			wire_q1.push_back(b);
		else
			wire_q0.push_back(b);
	endfunction

	// Queue one frame of n payload wire bytes; escaped marks take two wire bytes.
	function automatic void build_frame(input logic ch, input int unsigned n,
			input int unsigned esc_pct, input logic bad_tail);
		int unsigned left;
		// A length byte equal to the mark would restart the frame.
		if (n + 4 == efr_pkg::MARK_BYTE)
			n = n - 1;
		left = n;
		push_wire(ch, efr_pkg::MARK_BYTE);
		push_wire(ch, 8'(n + 4));
		push_wire(ch, rand_data_byte());
		while (left > 0) begin
			if (left >= 2 && $urandom_range(99) < esc_pct) begin
				push_wire(ch, efr_pkg::ESC_BYTE);
				push_wire(ch, efr_pkg::MARK_BYTE);
				left = left - 2;
			end else begin
				push_wire(ch, rand_data_byte());
				left = left - 1;
			end
		end
		push_wire(ch, bad_tail ? rand_data_byte() : efr_pkg::MARK_BYTE);
	endfunction

	// Mostly well-formed frames, the rest aborts, bad tails, cut frames and noise.
	function automatic void build_random_seq(input logic ch);
		int unsigned sel;
		int unsigned sz;
		int unsigned n;
		sel = $urandom_range(99);
		sz  = $urandom_range(99);
		if (sz < 85)
			n = $urandom_range(10);
		else if (sz < 98)
			n = $urandom_range(60, 11);
		else
			n = $urandom_range(251, 61);
		if (sel < 75) begin
			build_frame(ch, n, 20, 1'b0);
		end else if (sel < 80) begin
			push_wire(ch, efr_pkg::MARK_BYTE);
			push_wire(ch, 8'($urandom_range(3)));
		end else if (sel < 87) begin
			build_frame(ch, $urandom_range(10), 20, 1'b1);
		end else if (sel < 93) begin
			push_wire(ch, efr_pkg::MARK_BYTE);
			push_wire(ch, 8'($urandom_range(40, 5)));
			push_wire(ch, rand_data_byte());
			repeat ($urandom_range(2))
				push_wire(ch, rand_data_byte());
		end else begin
			repeat ($urandom_range(4, 1))
				push_wire(ch, 8'($urandom_range(255)));
		end
	endfunction

	// Sink: stall at random, or hold off for a whole requested stretch.
	always @(negedge clk) begin : sink_ctrl
		int unsigned seen_epoch;
		int unsigned hold_left;
		if (hold_epoch != seen_epoch) begin
			seen_epoch = hold_epoch;
			hold_left  = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compare each reply transfer, field by field, with the oldest prediction.
	always @(posedge clk) begin : reply_check
		frame_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: reply with none pending: %s",
						$realtime, $sformatf("done=%0b prop=%02h len=%0d rd=%02h",
						frame_done, frame_prop, frame_length, read_data));
			end else begin
				want = expected_replies.pop_front();
				if (frame_done !== want.frame_done || frame_prop !== want.frame_prop ||
						frame_length !== want.frame_length ||
						read_data !== want.read_data) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("%0t: mismatch exp %s got %s", $realtime,
							$sformatf("done=%0b prop=%02h len=%0d rd=%02h",
							want.frame_done, want.frame_prop, want.frame_length,
							want.read_data),
							$sformatf("done=%0b prop=%02h len=%0d rd=%02h",
							frame_done, frame_prop, frame_length, read_data));
				end
			end
		end
	end

	// Empty frame, escaped mark in the payload, and read-back of the payload.
	task automatic test_empty_and_escaped_frames();
		send_rx(1'b0, efr_pkg::MARK_BYTE);
		send_rx(1'b0, efr_pkg::MIN_WIRE);
		send_rx(1'b0, 8'h00);
		send_rx(1'b0, efr_pkg::MARK_BYTE);
		send_rx(1'b1, efr_pkg::MARK_BYTE);
		send_rx(1'b1, 8'd7);
		send_rx(1'b1, 8'hFF);
		send_rx(1'b1, 8'h00);
		send_rx(1'b1, efr_pkg::ESC_BYTE);
		send_rx(1'b1, efr_pkg::MARK_BYTE);
		send_rx(1'b1, efr_pkg::MARK_BYTE);
		send_read(1'b1, 8'd0);
		send_read(1'b1, 8'd1);
	endtask

	// Short length, stray byte in head, bad tail, and an unescaped mark mid-frame.
	task automatic test_abort_and_resync();
		send_rx(1'b0, efr_pkg::MARK_BYTE);
		send_rx(1'b0, 8'd3);
		send_rx(1'b0, 8'h55);
		send_rx(1'b0, efr_pkg::MARK_BYTE);
		send_rx(1'b0, 8'd5);
		send_rx(1'b0, 8'hAA);
		send_rx(1'b0, 8'h12);
		send_rx(1'b0, 8'h34);
		send_rx(1'b1, efr_pkg::MARK_BYTE);
		send_rx(1'b1, 8'd8);
		send_rx(1'b1, 8'h11);
		send_rx(1'b1, 8'h22);
		send_rx(1'b1, efr_pkg::MARK_BYTE);
		send_rx(1'b1, efr_pkg::MIN_WIRE);
		send_rx(1'b1, 8'h33);
		send_rx(1'b1, efr_pkg::MARK_BYTE);
		send_read(1'b0, 8'd0);
	endtask

	// Longest wire length: fills store positions up to the top one reachable.
	task automatic test_longest_frame();
		build_frame(1'b0, 251, 0, 1'b0);
		while (wire_q0.size() != 0)
			send_rx(1'b0, wire_q0.pop_front());
		send_read(1'b0, 8'd250);
		send_read(1'b0, 8'd4);
		send_read(1'b0, 8'd1);
	endtask

	// Interleaved channel traffic with reads of stored positions only.
	task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		logic        ch;
		logic [7:0]  ri;
		logic [7:0]  b;
		logic        have_ri;
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		repeat (count) begin
			ch      = 1'($urandom_range(1));
			have_ri = 1'b0;
			if ($urandom_range(99) < 15) begin
				// Never touch a position that no frame has written yet.
				repeat (8) begin
					if (!have_ri) begin
						ri = 8'($urandom_range(255));
						have_ri = payload_valid[ch][ri];
					end
				end
			end
			if (have_ri) begin
				send_read(ch, ri);
			end else begin
				if (ch ? (wire_q1.size() == 0) : (wire_q0.size() == 0))
					build_random_seq(ch);
				if (ch)
					b = wire_q1.pop_front();
				else
					b = wire_q0.pop_front();
				send_rx(ch, b);
			end
		end
	endtask

	// Hold the sink off while the sender keeps offering, so the block backs up
	// and drops in_ready; then pause the sender until all replies are back.
	task automatic test_output_holdoff();
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		hold_len        = 300;
		hold_epoch++;
		test_random_traffic(60, 0, 0);
		wait_replies_drained();
	endtask

	initial begin : run
		for (int i = 0; i < efr_pkg::CHANNELS_DEF; i++) begin
			chan_ctx[i] = efr_pkg::CTX_RESET;
			for (int j = 0; j < efr_pkg::PAYLOAD_DEPTH_DEF; j++) begin
				payload_mem[i][j]   = 8'd0;
				payload_valid[i][j] = 1'b0;
			end
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_and_escaped_frames();
		test_abort_and_resync();
		test_longest_frame();
		test_random_traffic(300, 0, 0);
		test_random_traffic(300, 76, 0);
		test_random_traffic(300, 0, 76);
		test_random_traffic(300, 27, 27);
		test_output_holdoff();

		// Drain, then keep clocking with the sink ready so stray replies show up.
		wait_replies_drained();
		sink_stall_pct = 0;
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_replies.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
sv/efr_pkg.sv
sv/escaped_frame_receiver_unit.sv
sim/tb_top.sv
